>>> rtl/ffr_pkg.sv
package ffr_pkg;

	localparam int DEF_FRAME_SLOTS = 8;
	localparam int DEF_MAX_PIECES  = 32;
	localparam int SLOT_IDX_W      = 6;

	localparam logic [1:0] STATUS_STALE = 2'd0;
	localparam logic [1:0] STATUS_PIECE = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_READ,
		ST_DECIDE,
		ST_SCAN,
		ST_EMIT
	} ffr_state_t;

	typedef struct packed {
		logic                  stale;
		logic                  found;
		logic [SLOT_IDX_W-1:0] hit;
		logic                  free_found;
		logic [SLOT_IDX_W-1:0] free_slot;
	} ffr_match_t;

endpackage

>>> rtl/ffr_slot_match.sv
module ffr_slot_match import ffr_pkg::*; #(
	parameter int FRAME_SLOTS = DEF_FRAME_SLOTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [63:0]                    frame,
	input  logic [63:0]                    newest,
	input  logic [FRAME_SLOTS-1:0]         in_use,
	input  logic [FRAME_SLOTS-1:0][63:0]   fid,
	output ffr_match_t                     match
);

	ffr_match_t match_d;

	// lowest matching slot and lowest free slot: scan down so the lowest wins
	always_comb begin
		match_d       = '0;
		match_d.stale = (frame <= newest);
		for (int i = FRAME_SLOTS - 1; i >= 0; i--) begin
			if (in_use[i] && fid[i] == frame) begin
				match_d.found = 1'b1;
				match_d.hit   = SLOT_IDX_W'(i);
			end
			if (!in_use[i]) begin
				match_d.free_found = 1'b1;
				match_d.free_slot  = SLOT_IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match <= '0;
		end else if (en) begin
			match <= match_d;
		end
	end

endmodule

>>> rtl/frame_fragment_reassembler.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+---------------------------------------------
// input    | start, busy        | frame_number, piece_index, piece_total,
//          | (start & !busy)    | payload_handle, payload_length
// result   | done (one cycle)   | status, out_frame_number, out_piece_index,
//          |                    | out_payload_handle, out_payload_length,
//          |                    | last_piece
//
// A stored item passes from accept through slot match, slot table read and
// update before the next accept. A stale or dropped item ends after the
// table read; its result shows in the next cycle.
// A completing frame of n fragments then drains by selection over the piece
// memory: each result takes a scan over all n stored fragments, then an emit.
// arst_n clears all slot valid bits and the done counter at once; the
// memories need no clearing. The receiver cannot stall: each result shows
// for exactly one cycle on done.
module frame_fragment_reassembler import ffr_pkg::*; #(
	parameter int FRAME_SLOTS = DEF_FRAME_SLOTS,
	parameter int MAX_PIECES  = DEF_MAX_PIECES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] frame_number,
	input  logic [7:0]  piece_index,
	input  logic [7:0]  piece_total,
	input  logic [15:0] payload_handle,
	input  logic [15:0] payload_length,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] out_frame_number,
	output logic [7:0]  out_piece_index,
	output logic [15:0] out_payload_handle,
	output logic [15:0] out_payload_length,
	output logic        last_piece
);

	localparam int SW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
	localparam int PW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
	localparam int CW = $clog2(MAX_PIECES + 1);
	localparam int PDEPTH = FRAME_SLOTS * (2 ** PW);

	ffr_state_t state_q, state_d;

	// latched input item
	logic [63:0] frame_q;
	logic [7:0]  idx_q, total_q;
	logic [15:0] handle_q, len_q;

	// slot table: valid bits and frame ids in flops, counts in memory
	logic [63:0]                   newest_q;
	logic [FRAME_SLOTS-1:0]        in_use_q;
	logic [FRAME_SLOTS-1:0][63:0]  fid_q;
	logic [2*CW-1:0]               slot_mem [FRAME_SLOTS];
	logic [2*CW-1:0]               slot_rd_q;

	// piece memory: {index, handle, length}
	logic [39:0] piece_mem [PDEPTH];
	logic [39:0] piece_rd_s1;

	ffr_match_t match;
	logic [SW-1:0] slot_q;
	logic          is_new_q;

	// drain scan
	logic [CW-1:0]   n_q, p_q, emit_cnt_q;
	logic            rd_v_s1;
	logic [PW-1:0]   p_s1;
	logic            have_prev_q, have_best_q;
	logic [PW+7:0]   prev_key_q, best_key_q;
	logic [15:0]     best_handle_q, best_len_q;

	// decide-stage values
	logic [CW-1:0] recv_old, recv_new, expect_val, clamp_total;
	logic          complete;
	logic [PW+7:0] cand_key;
	logic          cand_ok;

	ffr_slot_match #(.FRAME_SLOTS(FRAME_SLOTS)) u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (state_q == ST_LOOK),
		.frame  (frame_q),
		.newest (newest_q),
		.in_use (in_use_q),
		.fid    (fid_q),
		.match  (match)
	);

	assign busy = (state_q != ST_IDLE);

	// expected count: zero counts as one, saturate at the piece limit
	always_comb begin
		if (total_q == 8'd0)
			clamp_total = CW'(1);
		else if (32'(total_q) > MAX_PIECES)
			clamp_total = CW'(MAX_PIECES);
		else
			clamp_total = CW'(total_q);
	end

	always_comb begin
		recv_old   = is_new_q ? '0 : slot_rd_q[CW-1:0];
		expect_val = is_new_q ? clamp_total : slot_rd_q[2*CW-1:CW];
		recv_new   = (32'(recv_old) < MAX_PIECES) ? recv_old + CW'(1) : recv_old;
		complete   = (recv_new >= expect_val);
	end

	// stable ordering key: index first, then arrival position
	always_comb begin
		cand_key = {piece_rd_s1[39:32], p_s1};
		cand_ok  = (!have_prev_q || cand_key > prev_key_q) &&
		           (!have_best_q || cand_key < best_key_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_LOOK;
			ST_LOOK:   state_d = ST_READ;
			ST_READ: begin
				// stale and table-full items finish here
				if (match.stale || (!match.found && !match.free_found))
					state_d = ST_IDLE;
				else
					state_d = ST_DECIDE;
			end
			ST_DECIDE: state_d = complete ? ST_SCAN : ST_IDLE;
			ST_SCAN:   if (p_q == n_q && !rd_v_s1) state_d = ST_EMIT;
			ST_EMIT:   state_d = (emit_cnt_q + CW'(1) == n_q) ? ST_IDLE : ST_SCAN;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q    <= '0;
			in_use_q    <= '0;
			done        <= 1'b0;
			rd_v_s1     <= 1'b0;
			have_prev_q <= 1'b0;
			have_best_q <= 1'b0;
			p_q         <= '0;
			n_q         <= '0;
			emit_cnt_q  <= '0;
			is_new_q    <= 1'b0;
			slot_q      <= '0;
		end else begin
			done    <= 1'b0;
			rd_v_s1 <= 1'b0;
			case (state_q)
				ST_READ: begin
					if (match.stale) begin
						// free any open slot of a stale frame
						if (match.found)
							in_use_q[match.hit[SW-1:0]] <= 1'b0;
						done <= 1'b1;
					end else if (!match.found && !match.free_found) begin
						done <= 1'b1;
					end
					is_new_q <= !match.found;
					slot_q   <= match.found ? match.hit[SW-1:0] : match.free_slot[SW-1:0];
				end
				ST_DECIDE: begin
					in_use_q[slot_q] <= 1'b1;
					n_q              <= recv_new;
					p_q              <= '0;
					have_prev_q      <= 1'b0;
					have_best_q      <= 1'b0;
					emit_cnt_q       <= '0;
				end
				ST_SCAN: begin
					if (p_q != n_q) begin
						rd_v_s1 <= 1'b1;
						p_q     <= p_q + CW'(1);
					end
					if (rd_v_s1 && cand_ok)
						have_best_q <= 1'b1;
				end
				ST_EMIT: begin
					done        <= 1'b1;
					have_prev_q <= 1'b1;
					have_best_q <= 1'b0;
					p_q         <= '0;
					emit_cnt_q  <= emit_cnt_q + CW'(1);
					// last fragment out: release the slot, advance the counter
					if (emit_cnt_q + CW'(1) == n_q) begin
						in_use_q[slot_q] <= 1'b0;
						newest_q         <= newest_q + 64'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			frame_q  <= frame_number;
			idx_q    <= piece_index;
			total_q  <= piece_total;
			handle_q <= payload_handle;
			len_q    <= payload_length;
		end
		case (state_q)
			ST_READ: begin
				status             <= match.stale ? STATUS_STALE : STATUS_FULL;
				out_frame_number   <= frame_q;
				out_piece_index    <= idx_q;
				out_payload_handle <= handle_q;
				out_payload_length <= len_q;
				last_piece         <= 1'b0;
			end
			ST_DECIDE: begin
				if (is_new_q)
					fid_q[slot_q] <= frame_q;
			end
			ST_SCAN: begin
				p_s1 <= p_q[PW-1:0];
				if (rd_v_s1 && cand_ok) begin
					best_key_q    <= cand_key;
					best_handle_q <= piece_rd_s1[31:16];
					best_len_q    <= piece_rd_s1[15:0];
				end
			end
			ST_EMIT: begin
				status             <= STATUS_PIECE;
				out_frame_number   <= frame_q;
				out_piece_index    <= best_key_q[PW+7:PW];
				out_payload_handle <= best_handle_q;
				out_payload_length <= best_len_q;
				last_piece         <= (emit_cnt_q + CW'(1) == n_q);
				prev_key_q         <= best_key_q;
			end
			default: ;
		endcase
	end

	// slot count memory: read in READ, write back in DECIDE
	always_ff @(posedge clk) begin
		if (state_q == ST_READ)
			slot_rd_q <= slot_mem[match.found ? match.hit[SW-1:0] : match.free_slot[SW-1:0]];
		if (state_q == ST_DECIDE)
			slot_mem[slot_q] <= {expect_val, recv_new};
	end

	// piece memory: store on DECIDE, read during the drain scan
	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE && 32'(recv_old) < MAX_PIECES)
			piece_mem[{slot_q, recv_old[PW-1:0]}] <= {idx_q, handle_q, len_q};
		if (state_q == ST_SCAN)
			piece_rd_s1 <= piece_mem[{slot_q, p_q[PW-1:0]}];
	end

endmodule

>>> rtl/ffr_checker.sv
module ffr_checker import ffr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic        last_piece
);

	// status code three is never produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STATUS_STALE || status == STATUS_PIECE ||
		          status == STATUS_FULL))
		else $error("unknown status code");

	// only fragments of a completed frame carry the last mark
	a_last_piece: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last_piece) |-> (status == STATUS_PIECE))
		else $error("last mark on a non-fragment result");

	// busy rises only after an accepted item
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without an item");

	// a completed fragment is emitted while the drain still runs
	a_piece_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_PIECE) |-> $past(busy))
		else $error("fragment result outside a drain");

endmodule

bind frame_fragment_reassembler ffr_checker u_ffr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.last_piece (last_piece)
);

>>> sim/frame_fragment_reassembler_tb.sv
module frame_fragment_reassembler_tb;
	import ffr_pkg::*;

	localparam int SLOTS  = DEF_FRAME_SLOTS;
	localparam int PIECES = DEF_MAX_PIECES;

	// One emitted or rejected fragment as the block reports it.
	typedef struct {
		logic [1:0]  status;
		logic [63:0] frame;
		logic [7:0]  index;
		logic [15:0] handle;
		logic [15:0] length;
		logic        last;
	} frag_result_t;

	// One stored fragment waiting for its frame to complete.
	typedef struct {
		logic [7:0]  index;
		logic [15:0] handle;
		logic [15:0] length;
	} held_frag_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] frame_number;
	logic [7:0]  piece_index;
	logic [7:0]  piece_total;
	logic [15:0] payload_handle;
	logic [15:0] payload_length;
	logic        done;
	logic [1:0]  status;
	logic [63:0] out_frame_number;
	logic [7:0]  out_piece_index;
	logic [15:0] out_payload_handle;
	logic [15:0] out_payload_length;
	logic        last_piece;

	// Shadow of the reassembly table, updated as each item is accepted.
	logic [63:0]  done_count;
	bit           slot_busy [SLOTS];
	logic [63:0]  slot_frame [SLOTS];
	int           slot_want [SLOTS];
	int           slot_have [SLOTS];
	held_frag_t   slot_frags [SLOTS][PIECES];

	frag_result_t pending_results[$];
	int           mismatches;
	bit           allow_idle;

	frame_fragment_reassembler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.frame_number(frame_number), .piece_index(piece_index),
		.piece_total(piece_total), .payload_handle(payload_handle),
		.payload_length(payload_length), .done(done), .status(status),
		.out_frame_number(out_frame_number), .out_piece_index(out_piece_index),
		.out_payload_handle(out_payload_handle),
		.out_payload_length(out_payload_length), .last_piece(last_piece)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Append one expected result at the tail of the queue.
	function automatic void expect_result(input frag_result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Hand back a completed frame: stable insertion sort on index, so
	// duplicate indices come out in the order they arrived.
	task automatic release_frame(input int s);
		held_frag_t   sorted [PIECES];
		held_frag_t   v;
		frag_result_t r;
		int           n;
		int           j;
		n = slot_have[s];
		for (int i = 0; i < n; i++) begin
			v = slot_frags[s][i];
			j = i;
			while (j > 0 && sorted[j-1].index > v.index) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		for (int i = 0; i < n; i++) begin
			r.status = STATUS_PIECE;
			r.frame  = slot_frame[s];
			r.index  = sorted[i].index;
			r.handle = sorted[i].handle;
			r.length = sorted[i].length;
			r.last   = (i == n - 1);
			expect_result(r);
		end
		slot_busy[s] = 1'b0;
		done_count++;
	endtask

	// Work out what one accepted fragment header produces.
	task automatic predict_fragment(input logic [63:0] f, input logic [7:0] idx,
			input logic [7:0] tot, input logic [15:0] h, input logic [15:0] l);
		frag_result_t r;
		bit           found;
		int           hit;
		int           want;
		found = 1'b0;
		hit = 0;
		for (int s = 0; s < SLOTS; s++) begin
			if (!found && slot_busy[s] && slot_frame[s] == f) begin
				found = 1'b1;
				hit = s;
			end
		end
		r.frame  = f;
		r.index  = idx;
		r.handle = h;
		r.length = l;
		r.last   = 1'b0;
		// Stale frame: report it and drop any partial copy.
		if (f <= done_count) begin
			if (found)
				slot_busy[hit] = 1'b0;
			r.status = STATUS_STALE;
			expect_result(r);
			return;
		end
		if (!found) begin
			for (int s = SLOTS - 1; s >= 0; s--)
				if (!slot_busy[s]) begin
					found = 1'b1;
					hit = s;
				end
			// No free slot: the new frame is dropped.
			if (!found) begin
				r.status = STATUS_FULL;
				expect_result(r);
				return;
			end
			want = (tot == 0) ? 1 : int'(tot);
			if (want > PIECES)
				want = PIECES;
			slot_busy[hit]  = 1'b1;
			slot_frame[hit] = f;
			slot_want[hit]  = want;
			slot_have[hit]  = 0;
		end
		if (slot_have[hit] < PIECES) begin
			slot_frags[hit][slot_have[hit]] = '{idx, h, l};
			slot_have[hit]++;
		end
		if (slot_have[hit] >= slot_want[hit])
			release_frame(hit);
	endtask

	// Present one item, hold it until accepted, then predict. Start stays
	// high on return so back-to-back items need no extra edge.
	task automatic send_fragment(input logic [63:0] f, input logic [7:0] idx,
			input logic [7:0] tot, input logic [15:0] h, input logic [15:0] l);
		if (allow_idle && $urandom_range(0, 99) < 32) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start          <= 1'b1;
		frame_number   <= f;
		piece_index    <= idx;
		piece_total    <= tot;
		payload_handle <= h;
		payload_length <= l;
		do
			@(posedge clk);
		while (busy);
		predict_fragment(f, idx, tot, h, l);
	endtask

	// Send a whole frame with its fragments in shuffled order.
	task automatic send_frame(input logic [63:0] f, input int n, input logic [7:0] tot);
		int order[$];
		for (int i = 0; i < n; i++)
			order.insert(order.size(), i);
		order.shuffle();
		foreach (order[i])
			send_fragment(f, order[i][7:0], tot, 16'($urandom), 16'($urandom));
	endtask

	// Compare every strobed result with the oldest prediction.
	always @(posedge clk) begin
		frag_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: frame %h index %0d status %0d",
						out_frame_number, out_piece_index, status);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status || out_frame_number !== e.frame ||
						out_piece_index !== e.index || out_payload_handle !== e.handle ||
						out_payload_length !== e.length || last_piece !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %h %0d %h %h %0d, got %0d %h %0d %h %h %0d",
							e.status, e.frame, e.index, e.handle, e.length, e.last,
							status, out_frame_number, out_piece_index,
							out_payload_handle, out_payload_length, last_piece);
				end
			end
		end
	end

	// Field extremes: all-ones single frame, frame zero (stale), total zero.
	task automatic test_extremes();
		send_fragment('1, 8'hFF, 8'd1, 16'hFFFF, 16'hFFFF);
		send_fragment('0, 8'h00, 8'd0, 16'h0000, 16'h0000);
		send_fragment(done_count + 1, 8'hAA, 8'd0, 16'h5555, 16'hAAAA);
	endtask

	// Totals above the piece limit saturate to it.
	task automatic test_saturated_total();
		send_frame(done_count + 1, PIECES, 8'd200);
	endtask

	// Fill every slot, overflow with one more frame, then complete them all.
	task automatic test_table_full();
		logic [63:0] base;
		base = done_count;
		for (int s = 1; s <= SLOTS; s++)
			send_fragment(base + s, 8'd1, 8'd2, 16'($urandom), 16'($urandom));
		send_fragment(base + SLOTS + 1, 8'd0, 8'd2, 16'($urandom), 16'($urandom));
		for (int s = 1; s <= SLOTS; s++)
			send_fragment(base + s, 8'd0, 8'd2, 16'($urandom), 16'($urandom));
	endtask

	// A partial frame overtaken by the counter goes stale and frees its slot.
	task automatic test_stale_release();
		logic [63:0] base;
		base = done_count;
		send_fragment(base + 1, 8'd0, 8'd3, 16'($urandom), 16'($urandom));
		send_fragment(base + 2, 8'd0, 8'd1, 16'($urandom), 16'($urandom));
		send_fragment(base + 3, 8'd0, 8'd1, 16'($urandom), 16'($urandom));
		send_fragment(base + 1, 8'd1, 8'd3, 16'($urandom), 16'($urandom));
	endtask

	// Equal indices keep their arrival order.
	task automatic test_duplicates();
		logic [63:0] f;
		f = done_count + 1;
		send_fragment(f, 8'd4, 8'd3, 16'h0001, 16'h0011);
		send_fragment(f, 8'd4, 8'd3, 16'h0002, 16'h0022);
		send_fragment(f, 8'd2, 8'd3, 16'h0003, 16'h0033);
	endtask

	// Mostly well-formed frames, plus single huge frames, stale and junk items.
	task automatic test_random();
		int          sent;
		int          pick;
		int          n;
		logic [63:0] f;
		sent = 0;
		while (sent < 100) begin
			allow_idle = !(sent >= 30 && sent < 60);
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				n = $urandom_range(1, 6);
				send_frame(done_count + $urandom_range(1, 3), n, n[7:0]);
				sent += n;
			end else if (pick < 75) begin
				f = {$urandom, $urandom};
				send_fragment(f, 8'($urandom), 8'($urandom_range(0, 1)),
					16'($urandom), 16'($urandom));
				sent++;
			end else if (pick < 88) begin
				f = done_count - $urandom_range(0, 3);
				if (f > done_count)
					f = '0;
				send_fragment(f, 8'($urandom), 8'($urandom), 16'($urandom),
					16'($urandom));
				sent++;
			end else begin
				send_fragment(done_count + $urandom_range(1, 8), 8'($urandom),
					8'($urandom), 16'($urandom), 16'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		frame_number   = '0;
		piece_index    = '0;
		piece_total    = '0;
		payload_handle = '0;
		payload_length = '0;
		done_count     = '0;
		mismatches     = 0;
		allow_idle     = 1'b1;
		for (int s = 0; s < SLOTS; s++)
			slot_busy[s] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_saturated_total();
		test_table_full();
		test_stale_release();
		test_duplicates();
		test_random();

		start <= 1'b0;
		wait (pending_results.size() == 0);
		// Allow one full drain of the largest frame for anything stray.
		repeat (1200) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("frame_fragment_reassembler test passed");
		else
			$display("frame_fragment_reassembler test failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("frame_fragment_reassembler test failed");
		$finish;
	end

endmodule
